// ----- hdl/iss_pkg.sv -----
package iss_pkg;

  // Store depth and value width
  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]              count_t;

  // Controller to datapath
  typedef struct packed {
    logic insert;     // place the accepted input value into the store
    logic shift_out;  // result taken: move the store down by one cell
  } iss_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;      // no valid entries
    logic last_one;   // exactly one valid entry left
  } iss_sts_t;

endpackage

// ----- hdl/iss_ctrl.sv -----
module iss_ctrl
  import iss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  iss_sts_t sts,
  output iss_cmd_t cmd
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;
  logic in_xfer;
  logic out_xfer;

  // Handshakes: load while collecting, emit drives the result channel
  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_EMIT);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;

  assign cmd.insert    = in_xfer;
  assign cmd.shift_out = out_xfer;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_tlast) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer && sts.last_one) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Emitting never starts or runs with an empty store
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !sts.empty)
    else $error("emit state with empty store");

  // Taking the final result returns to loading
  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && sts.last_one) |=> in_tready && !out_tvalid)
    else $error("controller did not return to load after final result");

  // Load_end transaction starts the emit phase
  a_load_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> out_tvalid)
    else $error("load_end transaction did not start output");

endmodule

// ----- hdl/iss_datapath.sv -----
module iss_datapath
  import iss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  iss_cmd_t cmd,
  input  value_t   in_value,
  output value_t   head_value,
  output logic     drop_flag,
  output iss_sts_t sts
);

  value_t         store_r   [CAPACITY];
  value_t         store_nxt [CAPACITY];
  logic [CAPACITY-1:0] lt;
  count_t         fill_r;
  count_t         fill_nxt;
  logic           drop_r;
  logic           drop_nxt;
  logic           full;

  assign full          = (fill_r == count_t'(CAPACITY));
  assign head_value    = store_r[0];
  assign drop_flag     = drop_r;
  assign sts.empty     = (fill_r == '0);
  assign sts.last_one  = (fill_r == count_t'(1));

  // One comparator per cell: valid entries smaller than the new value stay put
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (count_t'(i) < fill_r) && (store_r[i] < in_value);
    end
  end

  // Cell updates: insert with shift up, or shift down on output
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (cmd.insert && !full) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (lt[i]) begin
          store_nxt[i] = store_r[i];
        end else if (i == 0) begin
          store_nxt[i] = in_value;
        end else if (lt[i-1]) begin
          store_nxt[i] = in_value;
        end else begin
          store_nxt[i] = store_r[i-1];
        end
      end
    end else if (cmd.shift_out) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        store_nxt[i] = store_r[i+1];
      end
    end
  end

  // Fill count and sticky drop flag
  always_comb begin
    fill_nxt = fill_r;
    drop_nxt = drop_r;
    if (cmd.insert) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + count_t'(1);
      end
    end else if (cmd.shift_out) begin
      fill_nxt = fill_r - count_t'(1);
      if (fill_r == count_t'(1)) drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      store_r[i] <= store_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      drop_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      drop_r <= drop_nxt;
    end
  end

  // Fill never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= count_t'(CAPACITY))
    else $error("fill count above capacity");

  // Insert and shift never come together
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.insert && cmd.shift_out))
    else $error("insert and shift_out in the same cycle");

  // Insert into a full store only raises the drop flag
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert && full) |=> drop_r && $stable(fill_r))
    else $error("insert into full store changed fill count");

endmodule

// ----- hdl/insertion_sorter_unit.sv -----
// Insertion sorter for signed values.
// Input stream (in_*): in_tdata carries one signed value, in_tlast marks the
// final item of a batch. Every accepted value is placed into a sorted row of
// cells, each with its own comparator, so a new value is accepted on every
// cycle while loading.
// After the in_tlast transaction the block stops taking input and emits the
// whole store in ascending order on out_*, one result per cycle while
// out_tready is high; the first result is valid the cycle after the
// in_tlast transaction. out_tlast marks the final result, and out_tuser is
// set on every result of a batch in which an item arrived at a full store
// and was dropped. After the final result is taken the store is empty and
// in_tready rises again on the next cycle. A stalled receiver simply holds
// the current result; nothing is lost. Reset (rst_n low, synchronous)
// empties the store and clears the drop flag; no clearing pass is needed.
module insertion_sorter_unit
  import iss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [VALUE_WIDTH-1:0] in_tdata,   // [31:0] item_value
  input  logic                   in_tlast,   // load_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [VALUE_WIDTH-1:0] out_tdata,  // [31:0] sorted_value
  output logic                   out_tlast,  // run_last
  output logic                   out_tuser   // items_dropped
);

  iss_cmd_t cmd;
  iss_sts_t sts;
  value_t   head_value;
  logic     drop_flag;

  iss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  iss_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (value_t'(in_tdata)),
    .head_value (head_value),
    .drop_flag  (drop_flag),
    .sts        (sts)
  );

  // Result fields come straight from the head cell
  assign out_tdata = head_value;
  assign out_tlast = sts.last_one;
  assign out_tuser = drop_flag;

endmodule

// ----- dv/insertion_sorter_unit_tb.sv -----
module insertion_sorter_unit_tb;
  import iss_pkg::*;

  localparam value_t VALUE_MAX  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN  = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam int     STALL_LIMIT = 2000;  // cycles without any transaction
  localparam int     DRAIN_CYCLES = 8;

  // One sorted result as it should leave the block
  typedef struct packed {
    value_t value;
    logic   last;
    logic   dropped;
  } sorted_result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  value_t       in_tdata   = '0;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  value_t       out_tdata;
  logic         out_tlast;
  logic         out_tuser;

  // Predicted store contents and drop state of the current batch
  value_t         batch_store[$];
  logic           batch_dropped = 1'b0;
  sorted_result_t pending_results[$];

  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  int unsigned    error_count = 0;
  int unsigned    quiet_cycles = 0;
  sorted_result_t want;

  insertion_sorter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Insert one value into the predicted store; on batch end queue the sorted run
  task automatic insert_and_emit(input value_t v, input logic last);
    int             pos;
    int             n;
    sorted_result_t res;
    pos = 0;
    if (batch_store.size() >= CAPACITY) begin
      batch_dropped = 1'b1;
    end else begin
      while (pos < batch_store.size() && batch_store[pos] < v) pos++;
      batch_store.insert(pos, v);
    end
    if (last) begin
      n = batch_store.size();
      for (int k = 0; k < n; k++) begin
        res.value   = batch_store[k];
        res.last    = (k == n - 1);
        res.dropped = batch_dropped;
        pending_results.insert(pending_results.size(), res);
      end
      batch_store.delete();
      batch_dropped = 1'b0;
    end
  endtask

  // Send one item; returns at the edge where the transaction happens.
  // in_tvalid is left high so back-to-back items need no re-raise.
  task automatic send_item(input value_t v, input logic last);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    insert_and_emit(v, last);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2, 3:    return value_t'(int'($urandom_range(8)) - 4);  // narrow range, many ties
      default: return value_t'($urandom());
    endcase
  endfunction

  // Batches of one item at both ends of the range
  task automatic test_single_item_batches();
    send_item(VALUE_MIN, 1'b1);
    send_item(VALUE_MAX, 1'b1);
  endtask

  task automatic test_extreme_values();
    send_item(VALUE_MAX, 1'b0);
    send_item(VALUE_MIN, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(value_t'(1), 1'b0);
    send_item(VALUE_MIN + 1, 1'b0);
    send_item(VALUE_MAX - 1, 1'b1);
  endtask

  // Duplicates land next to each other
  task automatic test_equal_values();
    send_item(value_t'(5), 1'b0);
    send_item(value_t'(-3), 1'b0);
    send_item(value_t'(5), 1'b0);
    send_item(value_t'(5), 1'b0);
    send_item(value_t'(-3), 1'b1);
  endtask

  task automatic test_reverse_order();
    for (int k = 3; k >= 0; k--) send_item(value_t'(k), k == 0);
  endtask

  // Fill the store; items past capacity (batch end included) are dropped
  task automatic test_full_store(input int n_items);
    for (int k = 0; k < n_items; k++) send_item(pick_value(), k == n_items - 1);
  endtask

  // Mostly short batches, now and then a long one
  task automatic test_random_batches(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) send_item(pick_value(), k == len - 1);
      sent += len;
    end
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare each result transaction with the oldest prediction
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual value=%0d last=%b dropped=%b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.value) begin
          error_count++;
          $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                   $time, want.value, out_tdata);
        end
        if (out_tlast !== want.last) begin
          error_count++;
          $display("%0t: run_last mismatch: expected %b, actual %b",
                   $time, want.last, out_tlast);
        end
        if (out_tuser !== want.dropped) begin
          error_count++;
          $display("%0t: items_dropped mismatch: expected %b, actual %b",
                   $time, want.dropped, out_tuser);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily
    tx_idle_pct = 17;
    rx_idle_pct = 53;
    test_single_item_batches();
    test_extreme_values();
    test_equal_values();
    test_reverse_order();
    test_full_store(CAPACITY + 2);
    test_random_batches(60);
    wait_drained();

    // Roles swapped
    tx_idle_pct = 53;
    rx_idle_pct = 17;
    test_full_store(CAPACITY);
    test_random_batches(60);
    wait_drained();

    // Full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_batches(60);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
